// File: src/triangle_rasterizer_zbuffer_defines.svh
// Assertion macros used by the rasterizer back end.
`ifndef TRIANGLE_RASTERIZER_ZBUFFER_DEFINES_SVH
`define TRIANGLE_RASTERIZER_ZBUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TRZB_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TRZB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/trzb_pkg.sv
package trzb_pkg;

	localparam int CANVAS_WIDTH = 128;
	localparam int CANVAS_HEIGHT = 128;
	localparam int STORE_SIZE = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int XW = $clog2(CANVAS_WIDTH);
	localparam int YW = $clog2(CANVAS_HEIGHT);
	localparam int COORD_W = 11;
	localparam int DEPTH_W = 8;
	localparam int COLOR_W = 24;
	localparam int COUNT_W = 15;
	localparam int DIFF_W = 13;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int EDGE_W = PROD_W + 2;
	localparam int MAG_W = 24;
	localparam int NUM_W = MAG_W + DEPTH_W;
	localparam int WORD_W = COLOR_W + DEPTH_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(CANVAS_WIDTH - 1);
	localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(CANVAS_HEIGHT - 1);

	typedef enum logic [1:0] {
		KIND_DRAW  = 2'd0,
		KIND_CULL  = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [COORD_W-1:0]  ax;
		logic signed [COORD_W-1:0]  ay;
		logic signed [COORD_W-1:0]  bx;
		logic signed [COORD_W-1:0]  by;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic [DEPTH_W-1:0]         az;
		logic [DEPTH_W-1:0]         bz;
		logic [DEPTH_W-1:0]         cz;
		logic [COLOR_W-1:0]         color;
		logic signed [EDGE_W-1:0]   a2;
		logic [XW-1:0]              x0;
		logic [XW-1:0]              x1;
		logic [YW-1:0]              y0;
		logic [YW-1:0]              y1;
	} job_t;

	function automatic logic signed [DIFF_W-1:0] sdiff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic logic signed [COORD_W-1:0] min3(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic signed [COORD_W-1:0] c
	);
		logic signed [COORD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [COORD_W-1:0] max3(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic signed [COORD_W-1:0] c
	);
		logic signed [COORD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [ADDR_W-1:0] pix_addr(
		input logic [XW-1:0] x,
		input logic [YW-1:0] y
	);
		return ADDR_W'(int'(y) * CANVAS_WIDTH + int'(x));
	endfunction

endpackage

// File: src/trzb_front.sv
module trzb_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  clear_done,
	input  logic                                  cmd,
	input  logic signed [trzb_pkg::COORD_W-1:0]   ax,
	input  logic signed [trzb_pkg::COORD_W-1:0]   ay,
	input  logic [trzb_pkg::DEPTH_W-1:0]          az,
	input  logic signed [trzb_pkg::COORD_W-1:0]   bx,
	input  logic signed [trzb_pkg::COORD_W-1:0]   by,
	input  logic [trzb_pkg::DEPTH_W-1:0]          bz,
	input  logic signed [trzb_pkg::COORD_W-1:0]   cx,
	input  logic signed [trzb_pkg::COORD_W-1:0]   cy,
	input  logic [trzb_pkg::DEPTH_W-1:0]          cz,
	input  logic [trzb_pkg::COLOR_W-1:0]          fill_color,
	output logic                                  push_valid,
	input  logic                                  push_ready,
	output trzb_pkg::job_t                        push_job
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_M1   = 4'b0010,
		F_M2   = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t                                 state_q;
	logic                                    cmd_q;
	trzb_pkg::job_t                          job_q;
	logic signed [trzb_pkg::PROD_W-1:0]      prod_q;
	logic signed [trzb_pkg::DIFF_W-1:0]      mul_a;
	logic signed [trzb_pkg::DIFF_W-1:0]      mul_b;
	logic signed [trzb_pkg::PROD_W-1:0]      prod;
	logic signed [trzb_pkg::EDGE_W-1:0]      a2;
	logic signed [trzb_pkg::COORD_W-1:0]     min_x;
	logic signed [trzb_pkg::COORD_W-1:0]     max_x;
	logic signed [trzb_pkg::COORD_W-1:0]     min_y;
	logic signed [trzb_pkg::COORD_W-1:0]     max_y;
	logic                                    box_empty;
	logic                                    read_inside;
	trzb_pkg::job_t                          next_job;

	assign in_ready = (state_q == F_IDLE) && clear_done;
	assign push_valid = (state_q == F_PUSH);
	assign push_job = job_q;

	always_comb begin
		mul_a = trzb_pkg::sdiff(job_q.cx, job_q.ax);
		mul_b = trzb_pkg::sdiff(job_q.by, job_q.ay);
		if (state_q == F_M2) begin
			mul_a = trzb_pkg::sdiff(job_q.cy, job_q.ay);
			mul_b = trzb_pkg::sdiff(job_q.bx, job_q.ax);
		end
	end

	assign prod = mul_a * mul_b;
	assign a2 = trzb_pkg::EDGE_W'(prod_q) - trzb_pkg::EDGE_W'(prod);

	assign min_x = trzb_pkg::min3(job_q.ax, job_q.bx, job_q.cx);
	assign max_x = trzb_pkg::max3(job_q.ax, job_q.bx, job_q.cx);
	assign min_y = trzb_pkg::min3(job_q.ay, job_q.by, job_q.cy);
	assign max_y = trzb_pkg::max3(job_q.ay, job_q.by, job_q.cy);
	assign box_empty = (max_x < 0) || (min_x > trzb_pkg::X_MAX) ||
		(max_y < 0) || (min_y > trzb_pkg::Y_MAX);
	assign read_inside = (job_q.ax >= 0) && (job_q.ax <= trzb_pkg::X_MAX) &&
		(job_q.ay >= 0) && (job_q.ay <= trzb_pkg::Y_MAX);

	always_comb begin
		next_job = job_q;
		next_job.a2 = a2;
		next_job.x0 = (min_x < 0) ? '0 : min_x[trzb_pkg::XW-1:0];
		next_job.y0 = (min_y < 0) ? '0 : min_y[trzb_pkg::YW-1:0];
		next_job.x1 = (max_x > trzb_pkg::X_MAX) ? trzb_pkg::X_MAX[trzb_pkg::XW-1:0] :
			max_x[trzb_pkg::XW-1:0];
		next_job.y1 = (max_y > trzb_pkg::Y_MAX) ? trzb_pkg::Y_MAX[trzb_pkg::YW-1:0] :
			max_y[trzb_pkg::YW-1:0];
		if (cmd_q) begin
			next_job.x0 = job_q.ax[trzb_pkg::XW-1:0];
			next_job.y0 = job_q.ay[trzb_pkg::YW-1:0];
			next_job.kind = read_inside ? trzb_pkg::KIND_READ : trzb_pkg::KIND_EMPTY;
		end else if (a2 > -2) begin
			next_job.kind = trzb_pkg::KIND_CULL;
		end else if (box_empty) begin
			next_job.kind = trzb_pkg::KIND_EMPTY;
		end else begin
			next_job.kind = trzb_pkg::KIND_DRAW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid && in_ready) state_q <= F_M1;
				end
				F_M1: state_q <= F_M2;
				F_M2: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && in_ready) begin
			cmd_q <= cmd;
			job_q.ax <= ax;
			job_q.ay <= ay;
			job_q.az <= az;
			job_q.bx <= bx;
			job_q.by <= by;
			job_q.bz <= bz;
			job_q.cx <= cx;
			job_q.cy <= cy;
			job_q.cz <= cz;
			job_q.color <= fill_color;
		end
		if (state_q == F_M1) prod_q <= prod;
		if (state_q == F_M2) job_q <= next_job;
	end

endmodule

// File: src/trzb_queue.sv
module trzb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  trzb_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output trzb_pkg::job_t  pop_job
);

	localparam int PTR_W = $clog2(trzb_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(trzb_pkg::QUEUE_DEPTH + 1);

	trzb_pkg::job_t     entry_q [trzb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(trzb_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = entry_q[rptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(trzb_pkg::QUEUE_DEPTH - 1)) ? '0 :
					PTR_W'(wptr_q + 1'b1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(trzb_pkg::QUEUE_DEPTH - 1)) ? '0 :
					PTR_W'(rptr_q + 1'b1);
			end
			if (do_push && !do_pop) count_q <= CNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wptr_q] <= push_job;
	end

endmodule

// File: src/trzb_back.sv
`include "triangle_rasterizer_zbuffer_defines.svh"

module trzb_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  trzb_pkg::job_t                    pop_job,
	output logic                              clear_done,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [trzb_pkg::COUNT_W-1:0]      pixels_written,
	output logic                              culled,
	output logic [trzb_pkg::COLOR_W-1:0]      read_color,
	output logic [trzb_pkg::DEPTH_W-1:0]      read_depth
);

	typedef enum logic [12:0] {
		B_CLEAR = 13'b0000000000001,
		B_IDLE  = 13'b0000000000010,
		B_S0    = 13'b0000000000100,
		B_S1    = 13'b0000000001000,
		B_S2    = 13'b0000000010000,
		B_S3    = 13'b0000000100000,
		B_PIX   = 13'b0000001000000,
		B_MUL   = 13'b0000010000000,
		B_DIV   = 13'b0000100000000,
		B_CMP   = 13'b0001000000000,
		B_RD0   = 13'b0010000000000,
		B_RD1   = 13'b0100000000000,
		B_DONE  = 13'b1000000000000
	} bstate_t;

	bstate_t                                state_q;
	trzb_pkg::job_t                         job_q;
	logic [trzb_pkg::ADDR_W-1:0]            clr_q;
	logic                                   clear_done_q;
	logic [trzb_pkg::XW-1:0]                x_q;
	logic [trzb_pkg::YW-1:0]                y_q;
	logic signed [trzb_pkg::EDGE_W-1:0]     e0_q;
	logic signed [trzb_pkg::EDGE_W-1:0]     e1_q;
	logic signed [trzb_pkg::EDGE_W-1:0]     e0r_q;
	logic signed [trzb_pkg::EDGE_W-1:0]     e1r_q;
	logic signed [trzb_pkg::PROD_W-1:0]     tmp_q;
	logic [trzb_pkg::MAG_W-1:0]             m0_q;
	logic [trzb_pkg::MAG_W-1:0]             m1_q;
	logic [trzb_pkg::MAG_W-1:0]             m2_q;
	logic [trzb_pkg::DEPTH_W-1:0]           z0_q;
	logic [trzb_pkg::DEPTH_W-1:0]           z1_q;
	logic [trzb_pkg::DEPTH_W-1:0]           z2_q;
	logic [1:0]                             step_q;
	logic [trzb_pkg::NUM_W-1:0]             acc_q;
	logic [trzb_pkg::NUM_W-1:0]             rem_q;
	logic [trzb_pkg::NUM_W-1:0]             dsh_q;
	logic [trzb_pkg::DEPTH_W-1:0]           qt_q;
	logic [2:0]                             dcnt_q;
	logic [trzb_pkg::COUNT_W-1:0]           cnt_q;
	logic                                   res_culled_q;
	logic [trzb_pkg::COLOR_W-1:0]           res_color_q;
	logic [trzb_pkg::DEPTH_W-1:0]           res_depth_q;
	logic                                   out_valid_q;
	logic [trzb_pkg::COUNT_W-1:0]           out_count_q;
	logic                                   out_culled_q;
	logic [trzb_pkg::COLOR_W-1:0]           out_color_q;
	logic [trzb_pkg::DEPTH_W-1:0]           out_depth_q;
	logic [trzb_pkg::WORD_W-1:0]            store_q [trzb_pkg::STORE_SIZE];
	logic [trzb_pkg::WORD_W-1:0]            rdata_q;

	logic signed [trzb_pkg::COORD_W-1:0]    x0s;
	logic signed [trzb_pkg::COORD_W-1:0]    y0s;
	logic signed [trzb_pkg::DIFF_W-1:0]     mul_a;
	logic signed [trzb_pkg::DIFF_W-1:0]     mul_b;
	logic signed [trzb_pkg::PROD_W-1:0]     prod;
	logic signed [trzb_pkg::EDGE_W-1:0]     setup_edge;
	logic signed [trzb_pkg::EDGE_W-1:0]     e2;
	logic signed [trzb_pkg::EDGE_W-1:0]     dx0;
	logic signed [trzb_pkg::EDGE_W-1:0]     dy0;
	logic signed [trzb_pkg::EDGE_W-1:0]     dx1;
	logic signed [trzb_pkg::EDGE_W-1:0]     dy1;
	logic                                   covered;
	logic                                   advance;
	logic                                   walk_end;
	logic                                   deeper;
	logic [trzb_pkg::NUM_W-1:0]             zprod;
	logic [trzb_pkg::MAG_W-1:0]             dvs;
	logic                                   we;
	logic [trzb_pkg::ADDR_W-1:0]            waddr;
	logic [trzb_pkg::WORD_W-1:0]            wdata;
	logic [trzb_pkg::ADDR_W-1:0]            raddr;
	logic                                   result_load;

	assign pop_ready = (state_q == B_IDLE);
	assign clear_done = clear_done_q;
	assign out_valid = out_valid_q;
	assign pixels_written = out_count_q;
	assign culled = out_culled_q;
	assign read_color = out_color_q;
	assign read_depth = out_depth_q;

	assign x0s = trzb_pkg::COORD_W'(job_q.x0);
	assign y0s = trzb_pkg::COORD_W'(job_q.y0);

	always_comb begin
		mul_a = trzb_pkg::sdiff(job_q.cx, x0s);
		mul_b = trzb_pkg::sdiff(job_q.by, y0s);
		unique case (state_q)
			B_S1: begin
				mul_a = trzb_pkg::sdiff(job_q.cy, y0s);
				mul_b = trzb_pkg::sdiff(job_q.bx, x0s);
			end
			B_S2: begin
				mul_a = trzb_pkg::sdiff(job_q.cx, job_q.ax);
				mul_b = trzb_pkg::sdiff(y0s, job_q.ay);
			end
			B_S3: begin
				mul_a = trzb_pkg::sdiff(job_q.cy, job_q.ay);
				mul_b = trzb_pkg::sdiff(x0s, job_q.ax);
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign setup_edge = trzb_pkg::EDGE_W'(tmp_q) - trzb_pkg::EDGE_W'(prod);

	assign dx0 = trzb_pkg::EDGE_W'(trzb_pkg::sdiff(job_q.cy, job_q.by));
	assign dy0 = trzb_pkg::EDGE_W'(trzb_pkg::sdiff(job_q.bx, job_q.cx));
	assign dx1 = trzb_pkg::EDGE_W'(trzb_pkg::sdiff(job_q.ay, job_q.cy));
	assign dy1 = trzb_pkg::EDGE_W'(trzb_pkg::sdiff(job_q.cx, job_q.ax));

	assign e2 = job_q.a2 - e0_q - e1_q;
	assign covered = (e0_q <= 0) && (e1_q <= 0) && (e2 <= 0);
	assign deeper = qt_q > rdata_q[trzb_pkg::DEPTH_W-1:0];
	assign advance = ((state_q == B_PIX) && !covered) || (state_q == B_CMP);
	assign walk_end = (x_q == job_q.x1) && (y_q == job_q.y1);
	assign zprod = trzb_pkg::NUM_W'(m0_q) * trzb_pkg::NUM_W'(z0_q);
	assign dvs = trzb_pkg::MAG_W'(-job_q.a2);
	assign result_load = (state_q == B_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		we = 1'b0;
		waddr = trzb_pkg::pix_addr(x_q, y_q);
		wdata = {job_q.color, qt_q};
		if (state_q == B_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == B_CMP) begin
			we = deeper;
		end
	end

	assign raddr = (state_q == B_RD0) ? trzb_pkg::pix_addr(job_q.x0, job_q.y0) :
		trzb_pkg::pix_addr(x_q, y_q);

	always_ff @(posedge clk) begin
		if (we) store_q[waddr] <= wdata;
		rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			clear_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= trzb_pkg::ADDR_W'(clr_q + 1'b1);
					if (clr_q == trzb_pkg::ADDR_W'(trzb_pkg::STORE_SIZE - 1)) begin
						clear_done_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						unique case (pop_job.kind)
							trzb_pkg::KIND_DRAW: state_q <= B_S0;
							trzb_pkg::KIND_READ: state_q <= B_RD0;
							default: state_q <= B_DONE;
						endcase
					end
				end
				B_S0: state_q <= B_S1;
				B_S1: state_q <= B_S2;
				B_S2: state_q <= B_S3;
				B_S3: state_q <= B_PIX;
				B_PIX: begin
					if (covered) state_q <= B_MUL;
					else if (walk_end) state_q <= B_DONE;
				end
				B_MUL: begin
					if (step_q == 2'd2) state_q <= B_DIV;
				end
				B_DIV: begin
					if (dcnt_q == '0) state_q <= B_CMP;
				end
				B_CMP: state_q <= walk_end ? B_DONE : B_PIX;
				B_RD0: state_q <= B_RD1;
				B_RD1: state_q <= B_DONE;
				B_DONE: begin
					if (result_load) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			job_q <= pop_job;
			cnt_q <= '0;
			res_culled_q <= (pop_job.kind == trzb_pkg::KIND_CULL);
			res_color_q <= '0;
			res_depth_q <= '0;
		end
		if (state_q == B_S0 || state_q == B_S2) tmp_q <= prod;
		if (state_q == B_S0) begin
			x_q <= job_q.x0;
			y_q <= job_q.y0;
		end
		if (state_q == B_S1) begin
			e0_q <= setup_edge;
			e0r_q <= setup_edge;
		end
		if (state_q == B_S3) begin
			e1_q <= setup_edge;
			e1r_q <= setup_edge;
		end
		if (state_q == B_PIX && covered) begin
			m0_q <= trzb_pkg::MAG_W'(-e0_q);
			m1_q <= trzb_pkg::MAG_W'(-e1_q);
			m2_q <= trzb_pkg::MAG_W'(-e2);
			z0_q <= job_q.az;
			z1_q <= job_q.bz;
			z2_q <= job_q.cz;
			step_q <= '0;
			acc_q <= '0;
		end
		if (state_q == B_MUL) begin
			m0_q <= m1_q;
			m1_q <= m2_q;
			z0_q <= z1_q;
			z1_q <= z2_q;
			step_q <= 2'(step_q + 1'b1);
			acc_q <= acc_q + zprod;
			if (step_q == 2'd2) begin
				rem_q <= acc_q + zprod;
				dsh_q <= trzb_pkg::NUM_W'(dvs) << (trzb_pkg::DEPTH_W - 1);
				qt_q <= '0;
				dcnt_q <= 3'(trzb_pkg::DEPTH_W - 1);
			end
		end
		if (state_q == B_DIV) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				qt_q <= {qt_q[trzb_pkg::DEPTH_W-2:0], 1'b1};
			end else begin
				qt_q <= {qt_q[trzb_pkg::DEPTH_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
			dcnt_q <= 3'(dcnt_q - 1'b1);
		end
		if (state_q == B_CMP && deeper) cnt_q <= trzb_pkg::COUNT_W'(cnt_q + 1'b1);
		if (advance && !walk_end) begin
			if (y_q == job_q.y1) begin
				x_q <= trzb_pkg::XW'(x_q + 1'b1);
				y_q <= job_q.y0;
				e0r_q <= e0r_q + dx0;
				e0_q <= e0r_q + dx0;
				e1r_q <= e1r_q + dx1;
				e1_q <= e1r_q + dx1;
			end else begin
				y_q <= trzb_pkg::YW'(y_q + 1'b1);
				e0_q <= e0_q + dy0;
				e1_q <= e1_q + dy1;
			end
		end
		if (state_q == B_RD1) begin
			res_color_q <= rdata_q[trzb_pkg::WORD_W-1:trzb_pkg::DEPTH_W];
			res_depth_q <= rdata_q[trzb_pkg::DEPTH_W-1:0];
		end
		if (result_load) begin
			out_count_q <= cnt_q;
			out_culled_q <= res_culled_q;
			out_color_q <= res_color_q;
			out_depth_q <= res_depth_q;
		end
	end

	`TRZB_ASSERT_NEXT(a_clear_sticky, clear_done_q, clear_done_q, "clear done dropped")
	`TRZB_ASSERT(a_no_pop_in_clear, !clear_done_q, !pop_ready, "pop during clearing pass")
	`TRZB_ASSERT(a_walk_in_box, state_q == B_PIX, x_q <= job_q.x1 && y_q <= job_q.y1, "walk left box")
	`TRZB_ASSERT(a_write_deeper, we && clear_done_q, deeper, "store write without depth win")

endmodule

// File: src/triangle_rasterizer_zbuffer.sv
// Triangle rasterizer with a 128 by 128 depth and color store. After reset the store is
// cleared and in_ready stays low until that ends. A draw transaction passes the front-end
// states F_M1 and F_M2 for the area test and, in the back end, setup states B_S0 to B_S3,
// then B_PIX for every pixel of the clipped bounding box and, for every covered pixel, the
// shared blend multiplier, the eight-step depth divider and B_CMP. Culled and off-canvas jobs
// go from B_IDLE to B_DONE, a read passes B_RD0 and B_RD1. A two-entry queue lets new
// transactions be taken while the back end walks a triangle or a result waits to be taken.
module triangle_rasterizer_zbuffer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic signed [trzb_pkg::COORD_W-1:0]   ax,
	input  logic signed [trzb_pkg::COORD_W-1:0]   ay,
	input  logic [trzb_pkg::DEPTH_W-1:0]          az,
	input  logic signed [trzb_pkg::COORD_W-1:0]   bx,
	input  logic signed [trzb_pkg::COORD_W-1:0]   by,
	input  logic [trzb_pkg::DEPTH_W-1:0]          bz,
	input  logic signed [trzb_pkg::COORD_W-1:0]   cx,
	input  logic signed [trzb_pkg::COORD_W-1:0]   cy,
	input  logic [trzb_pkg::DEPTH_W-1:0]          cz,
	input  logic [trzb_pkg::COLOR_W-1:0]          fill_color,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [trzb_pkg::COUNT_W-1:0]          pixels_written,
	output logic                                  culled,
	output logic [trzb_pkg::COLOR_W-1:0]          read_color,
	output logic [trzb_pkg::DEPTH_W-1:0]          read_depth
);

	logic            clear_done;
	logic            push_valid;
	logic            push_ready;
	trzb_pkg::job_t  push_job;
	logic            pop_valid;
	logic            pop_ready;
	trzb_pkg::job_t  pop_job;

	trzb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.clear_done (clear_done),
		.cmd        (cmd),
		.ax         (ax),
		.ay         (ay),
		.az         (az),
		.bx         (bx),
		.by         (by),
		.bz         (bz),
		.cx         (cx),
		.cy         (cy),
		.cz         (cz),
		.fill_color (fill_color),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	trzb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	trzb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_job        (pop_job),
		.clear_done     (clear_done),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixels_written (pixels_written),
		.culled         (culled),
		.read_color     (read_color),
		.read_depth     (read_depth)
	);

endmodule

// File: verif/testbench.sv
module testbench;
	import trzb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 580;
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct {
		logic                      cmd;
		logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
		logic [DEPTH_W-1:0]        az, bz, cz;
		logic [COLOR_W-1:0]        color;
	} tri_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               culled;
		logic [COLOR_W-1:0] rcolor;
		logic [DEPTH_W-1:0] rdepth;
	} pix_result_t;

	typedef struct {
		tri_t        item;
		logic        typed;
		pix_result_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
	logic [DEPTH_W-1:0] az, bz, cz;
	logic [COLOR_W-1:0] fill_color;
	logic out_valid;
	logic out_ready;
	logic [COUNT_W-1:0] pixels_written;
	logic culled;
	logic [COLOR_W-1:0] read_color;
	logic [DEPTH_W-1:0] read_depth;

	logic [DEPTH_W-1:0] depth_mem [STORE_SIZE];
	logic [COLOR_W-1:0] color_mem [STORE_SIZE];
	pix_result_t expected_pixels [$];
	row_t directed_rows [$];
	logic cur_typed;
	pix_result_t cur_want;
	int in_idle_pct;
	int out_idle_pct;
	int errors;
	int idle_cycles;
	int n_draw, n_cull, n_read;

	triangle_rasterizer_zbuffer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz), .fill_color(fill_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixels_written(pixels_written), .culled(culled),
		.read_color(read_color), .read_depth(read_depth)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint area2(tri_t t);
		longint pax, pay, pbx, pby, pcx, pcy;
		pax = t.ax; pay = t.ay; pbx = t.bx; pby = t.by; pcx = t.cx; pcy = t.cy;
		return (pcx - pax) * (pby - pay) - (pcy - pay) * (pbx - pax);
	endfunction

	function automatic pix_result_t rasterize(tri_t t);
		pix_result_t r;
		longint pax, pay, pbx, pby, pcx, pcy, a2, x0, x1, y0, y1, x, y;
		longint e0, e1, e2, num, z, idx, written;
		r = '{default: '0};
		pax = t.ax; pay = t.ay; pbx = t.bx; pby = t.by; pcx = t.cx; pcy = t.cy;
		if (t.cmd == CMD_READ) begin
			if (pax >= 0 && pax < CANVAS_WIDTH && pay >= 0 && pay < CANVAS_HEIGHT) begin
				idx = pay * CANVAS_WIDTH + pax;
				r.rcolor = color_mem[idx];
				r.rdepth = depth_mem[idx];
			end
			return r;
		end
		a2 = area2(t);
		if (a2 > -2) begin
			r.culled = 1'b1;
			return r;
		end
		x0 = pax < pbx ? pax : pbx; x0 = x0 < pcx ? x0 : pcx; if (x0 < 0) x0 = 0;
		y0 = pay < pby ? pay : pby; y0 = y0 < pcy ? y0 : pcy; if (y0 < 0) y0 = 0;
		x1 = pax > pbx ? pax : pbx; x1 = x1 > pcx ? x1 : pcx;
		if (x1 > CANVAS_WIDTH - 1) x1 = CANVAS_WIDTH - 1;
		y1 = pay > pby ? pay : pby; y1 = y1 > pcy ? y1 : pcy;
		if (y1 > CANVAS_HEIGHT - 1) y1 = CANVAS_HEIGHT - 1;
		written = 0;
		for (x = x0; x <= x1; x++) begin
			for (y = y0; y <= y1; y++) begin
				e0 = (pcx - x) * (pby - y) - (pcy - y) * (pbx - x);
				e1 = (pcx - pax) * (y - pay) - (pcy - pay) * (x - pax);
				e2 = a2 - e0 - e1;
				if (e0 <= 0 && e1 <= 0 && e2 <= 0) begin
					num = (-e0) * t.az + (-e1) * t.bz + (-e2) * t.cz;
					z = num / (-a2);
					if (z > 255) z = 255;
					idx = y * CANVAS_WIDTH + x;
					if (z > depth_mem[idx]) begin
						depth_mem[idx] = z[7:0];
						color_mem[idx] = t.color;
						written++;
					end
				end
			end
		end
		r.count = written[COUNT_W-1:0];
		return r;
	endfunction

	function automatic tri_t make_tri(logic c, int pax, int pay, int pbx, int pby,
			int pcx, int pcy, int paz, int pbz, int pcz, int col);
		tri_t t;
		t.cmd = c;
		t.ax = COORD_W'(pax); t.ay = COORD_W'(pay);
		t.bx = COORD_W'(pbx); t.by = COORD_W'(pby);
		t.cx = COORD_W'(pcx); t.cy = COORD_W'(pcy);
		t.az = DEPTH_W'(paz); t.bz = DEPTH_W'(pbz); t.cz = DEPTH_W'(pcz);
		t.color = COLOR_W'(col);
		return t;
	endfunction

	function automatic void add_row(tri_t t, logic typed, int cnt, logic cul, int rc, int rd);
		row_t row;
		row.item = t;
		row.typed = typed;
		row.want.count = COUNT_W'(cnt);
		row.want.culled = cul;
		row.want.rcolor = COLOR_W'(rc);
		row.want.rdepth = DEPTH_W'(rd);
		directed_rows.push_back(row);
	endfunction

	function automatic longint clipped_box(tri_t t);
		longint x0, x1, y0, y1;
		x0 = t.ax; if (t.bx < x0) x0 = t.bx; if (t.cx < x0) x0 = t.cx; if (x0 < 0) x0 = 0;
		y0 = t.ay; if (t.by < y0) y0 = t.by; if (t.cy < y0) y0 = t.cy; if (y0 < 0) y0 = 0;
		x1 = t.ax; if (t.bx > x1) x1 = t.bx; if (t.cx > x1) x1 = t.cx;
		if (x1 > CANVAS_WIDTH - 1) x1 = CANVAS_WIDTH - 1;
		y1 = t.ay; if (t.by > y1) y1 = t.by; if (t.cy > y1) y1 = t.cy;
		if (y1 > CANVAS_HEIGHT - 1) y1 = CANVAS_HEIGHT - 1;
		if (x1 < x0 || y1 < y0) return 0;
		return (x1 - x0 + 1) * (y1 - y0 + 1);
	endfunction

	function automatic tri_t random_tri();
		tri_t t;
		logic signed [COORD_W-1:0] sx, sy;
		int pick, bx0, by0;
		pick = $urandom_range(99);
		t.cmd = CMD_DRAW;
		t.az = DEPTH_W'($urandom); t.bz = DEPTH_W'($urandom); t.cz = DEPTH_W'($urandom);
		t.color = COLOR_W'($urandom);
		if (pick < 80) begin
			bx0 = $urandom_range(143) - 8;
			by0 = $urandom_range(143) - 8;
			t.ax = COORD_W'(bx0); t.ay = COORD_W'(by0);
			t.bx = COORD_W'(bx0 + $urandom_range(20) - 10);
			t.by = COORD_W'(by0 + $urandom_range(20) - 10);
			t.cx = COORD_W'(bx0 + $urandom_range(20) - 10);
			t.cy = COORD_W'(by0 + $urandom_range(20) - 10);
		end else if (pick < 90) begin
			t.cmd = CMD_READ;
			t.ax = COORD_W'($urandom_range(129) - 1); t.ay = COORD_W'($urandom_range(129) - 1);
			t.bx = COORD_W'($urandom); t.by = COORD_W'($urandom);
			t.cx = COORD_W'($urandom); t.cy = COORD_W'($urandom);
		end else begin
			t.cmd = pick < 95 ? CMD_READ : CMD_DRAW;
			t.ax = COORD_W'($urandom); t.ay = COORD_W'($urandom); t.bx = COORD_W'($urandom);
			t.by = COORD_W'($urandom); t.cx = COORD_W'($urandom); t.cy = COORD_W'($urandom);
			if (t.cmd == CMD_DRAW && area2(t) <= -2 && clipped_box(t) > 1024) begin
				sx = t.bx; sy = t.by;
				t.bx = t.cx; t.by = t.cy;
				t.cx = sx; t.cy = sy;
			end
		end
		return t;
	endfunction

	task automatic send(tri_t t, logic typed, pix_result_t want);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= t.cmd;
		ax <= t.ax; ay <= t.ay; az <= t.az;
		bx <= t.bx; by <= t.by; bz <= t.bz;
		cx <= t.cx; cy <= t.cy; cz <= t.cz;
		fill_color <= t.color;
		cur_typed <= typed;
		cur_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	task automatic drain();
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		tri_t t;
		pix_result_t r;
		if (arst_n && in_valid && in_ready) begin
			t.cmd = cmd;
			t.ax = ax; t.ay = ay; t.az = az;
			t.bx = bx; t.by = by; t.bz = bz;
			t.cx = cx; t.cy = cy; t.cz = cz;
			t.color = fill_color;
			r = rasterize(t);
			if (cur_typed)
				r = cur_want;
			if (t.cmd == CMD_READ) n_read++;
			else if (r.culled) n_cull++;
			else n_draw++;
			expected_pixels.push_back(r);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				r = expected_pixels.pop_front();
				if (pixels_written !== r.count)
					report_mismatch("pixels_written", pixels_written, r.count);
				if (culled !== r.culled)
					report_mismatch("culled", culled, r.culled);
				if (read_color !== r.rcolor)
					report_mismatch("read_color", read_color, r.rcolor);
				if (read_depth !== r.rdepth)
					report_mismatch("read_depth", read_depth, r.rdepth);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pix_result_t none;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cmd = CMD_DRAW;
		{ax, ay, bx, by, cx, cy} = '0;
		{az, bz, cz} = '0;
		fill_color = '0;
		cur_typed = 1'b0;
		cur_want = '{default: '0};
		none = '{default: '0};
		errors = 0;
		idle_cycles = 0;
		n_draw = 0; n_cull = 0; n_read = 0;
		in_idle_pct = 24;
		out_idle_pct = 82;
		for (int i = 0; i < STORE_SIZE; i++) begin
			depth_mem[i] = '0;
			color_mem[i] = '0;
		end

		add_row(make_tri(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, -1024, 1023, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_DRAW, 7, 7, 7, 7, 7, 7, 9, 9, 9, 'h123456), 1, 0, 1, 0, 0);
		add_row(make_tri(CMD_DRAW, 0, 0, 1, 0, 0, 1, 50, 50, 50, 'h1), 1, 0, 1, 0, 0);
		add_row(make_tri(CMD_DRAW, 0, 0, 0, 5, 5, 0, 50, 50, 50, 'h2), 1, 0, 1, 0, 0);
		add_row(make_tri(CMD_DRAW, -100, -100, -50, -100, -100, -50, 9, 9, 9, 'h3),
			1, 0, 0, 0, 0);
		add_row(make_tri(CMD_DRAW, 200, 0, 300, 0, 200, 100, 9, 9, 9, 'h4), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_DRAW, -1024, -1024, 1023, 1023, -1024, -1024, 255, 255, 255,
			'hffffff), 1, 0, 1, 0, 0);
		add_row(make_tri(CMD_DRAW, -1, -1, 1023, -1, -1, 1023, 1, 1, 1, 'hffffff),
			1, 16384, 0, 0, 0);
		add_row(make_tri(CMD_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 'hffffff, 1);
		add_row(make_tri(CMD_DRAW, -1, -1, 1023, -1, -1, 1023, 1, 1, 1, 'h00ff00),
			1, 0, 0, 0, 0);
		add_row(make_tri(CMD_DRAW, 10, 10, 30, 10, 10, 30, 255, 0, 128, 'habcdef), 0, 0, 0, 0, 0);
		add_row(make_tri(CMD_DRAW, 50, 50, 60, 50, 50, 60, 255, 255, 255, 'h000000),
			0, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, 50, 50, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, 12, 12, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_tri(CMD_READ, 0, 128, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		in_valid <= 1'b0;
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				in_idle_pct = 82;
				out_idle_pct = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			send(random_tri(), 1'b0, none);
		end
		in_valid <= 1'b0;
		drain();
		repeat (100) @(posedge clk);

		$display("Covered %0d drawn, %0d culled and %0d read transactions,", n_draw, n_cull,
			n_read);
		$display("including off-canvas boxes, full-canvas fills and equal-depth redraws.");
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/trzb_pkg.sv
src/trzb_front.sv
src/trzb_queue.sv
src/trzb_back.sv
src/triangle_rasterizer_zbuffer.sv
verif/testbench.sv
